### design/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

    localparam int NUM_PAGES = 4096;

    localparam int OP_W    = 1;
    localparam int ORDER_W = 4;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;

    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ASCAN,
        S_UN1,
        S_UN2,
        S_UN3,
        S_SPLIT,
        S_SPL2,
        S_SPL3,
        S_FCHK,
        S_FDBL,
        S_FBUD,
        S_FBCK,
        S_FPUSH,
        S_FPSH2,
        S_DONE
    } t_state;

    // field write enables and read strobe of the page store
    typedef struct packed {
        logic rd;
        logic wr_next;
        logic wr_prev;
        logic wr_flag;
    } t_mem_ctl;

endpackage
`default_nettype wire

### design/bpa_req_if.sv
`default_nettype none
interface bpa_req_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [ORDER_W-1:0] order;
    logic [INDEX_W-1:0] block_index;

    modport source (output valid, output operation, output order, output block_index,
                    input ready);
    modport sink (input valid, input operation, input order, input block_index,
                  output ready);
endinterface
`default_nettype wire

### design/bpa_rsp_if.sv
`default_nettype none
interface bpa_rsp_if import bpa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               granted;
    logic [INDEX_W-1:0] result_index;
    logic [COUNT_W-1:0] free_page_count;

    modport source (output valid, output granted, output result_index,
                    output free_page_count, input ready);
    modport sink (input valid, input granted, input result_index,
                  input free_page_count, output ready);
endinterface
`default_nettype wire

### design/bpa_page_mem.sv
`default_nettype none
module bpa_page_mem import bpa_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int LW    = 13,
    parameter int FW    = 5
) (
    input  wire logic          i_clk,
    input  wire t_mem_ctl      i_ctl,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [LW-1:0] i_wd_next,
    input  wire logic [LW-1:0] i_wd_prev,
    input  wire logic [FW-1:0] i_wd_flag,
    output logic      [LW-1:0] o_rd_next,
    output logic      [LW-1:0] o_rd_prev,
    output logic      [FW-1:0] o_rd_flag
);

    logic [LW-1:0] mem_next [DEPTH];
    logic [LW-1:0] mem_prev [DEPTH];
    logic [FW-1:0] mem_flag [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_next) begin
            mem_next[i_wr_addr] <= i_wd_next;
        end
        if (i_ctl.wr_prev) begin
            mem_prev[i_wr_addr] <= i_wd_prev;
        end
        if (i_ctl.wr_flag) begin
            mem_flag[i_wr_addr] <= i_wd_flag;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            o_rd_next <= mem_next[i_rd_addr];
            o_rd_prev <= mem_prev[i_rd_addr];
            o_rd_flag <= mem_flag[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### design/buddy_page_allocator_unit.sv
// channel   dir  fields                                        beat when
// i_req     in   operation, order, block_index                 valid && ready
// o_rsp     out  granted, result_index, free_page_count        valid && ready
// i_cfg     in   i_zone_pages (zone_pages)                     i_zone_pages_we
//
// After reset a clearing pass over all NUM_PAGES (4096) entries wipes the page store;
// no beat is taken meanwhile. One item at a time: the page store has one read and one
// write port, so each list unlink steps through S_UN1 to S_UN3, each split step through
// S_SPLIT to S_SPL3 and each push through S_FPUSH and S_FPSH2. A held result does not
// block the next request; that item waits in S_DONE until the result register frees.
`default_nettype none
module buddy_page_allocator_unit import bpa_pkg::*; #(
    parameter int ORDER_COUNT = 11
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_zone_pages_we,
    input  wire logic [COUNT_W-1:0] i_zone_pages,
    bpa_req_if.sink                 i_req,
    bpa_rsp_if.source               o_rsp
);

    localparam int PW   = $clog2(NUM_PAGES);
    localparam int LW   = PW + 1;
    localparam int OW   = (ORDER_COUNT > 2) ? $clog2(ORDER_COUNT) : 1;
    localparam int OCW  = $clog2(ORDER_COUNT + 1);
    localparam int FW   = OW + 1;
    localparam int WA   = (LW > ORDER_COUNT) ? LW : ORDER_COUNT;
    localparam int WW   = ((WA > COUNT_W) ? WA : COUNT_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);

    t_state          r_state, n_state;
    logic [PW-1:0]   r_clr, n_clr;
    logic [OCW-1:0]  r_o, n_o;
    logic [OCW-1:0]  r_req;
    logic [OP_W-1:0] r_op;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_u, n_u;
    logic [PW-1:0]   r_half, n_half;
    logic            r_grant, n_grant;
    logic [PW-1:0]   r_res, n_res;
    logic [COUNT_W-1:0] r_zone;
    logic [LW-1:0]   r_head [ORDER_COUNT];
    logic [LW-1:0]   r_tail [ORDER_COUNT];
    logic [LW-1:0]   r_cnt  [ORDER_COUNT];
    logic [LW-1:0]   r_total;
    logic            r_ov;
    logic            r_gr;
    logic [PW-1:0]   r_ri;
    logic [LW-1:0]   r_fp;

    t_mem_ctl        mem_ctl;
    logic [PW-1:0]   rd_addr, wr_addr;
    logic [LW-1:0]   wd_next, wd_prev, rd_next, rd_prev;
    logic [FW-1:0]   wd_flag, rd_flag;

    logic [OW-1:0]   oi;
    logic [LW-1:0]   h, t;
    logic            in_acc, order_bad, idx_bad;
    logic [WW-1:0]   lim, idxw, size_w, sum_w;
    logic            aligned, fits;
    logic [PW-1:0]   bud;
    logic            bud_ok;
    logic [LW-1:0]   asize;
    logic            head_we, tail_we, cnt_inc, cnt_dec, total_we;
    logic [LW-1:0]   head_wd, tail_wd, total_wd;

    bpa_page_mem #(
        .DEPTH (NUM_PAGES),
        .AW    (PW),
        .LW    (LW),
        .FW    (FW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wd_next (wd_next),
        .i_wd_prev (wd_prev),
        .i_wd_flag (wd_flag),
        .o_rd_next (rd_next),
        .o_rd_prev (rd_prev),
        .o_rd_flag (rd_flag)
    );

    assign oi        = r_o[OW-1:0];
    assign h         = r_head[oi];
    assign t         = r_tail[oi];
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc    = i_req.valid && i_req.ready;
    assign order_bad = 32'(i_req.order) >= ORDER_COUNT;
    assign idx_bad   = 32'(i_req.block_index) >= NUM_PAGES;

    assign lim    = (WW'(r_zone) > WW'(NUM_PAGES)) ? WW'(NUM_PAGES) : WW'(r_zone);
    assign idxw   = WW'(r_p);
    assign size_w = WW'(1) << r_o;
    assign aligned = (idxw & (size_w - WW'(1))) == '0;
    assign fits    = (idxw < lim) && (size_w <= lim - idxw);
    assign sum_w   = WW'(r_total) + size_w;
    assign bud     = r_p ^ (PW'(1) << r_o);
    assign bud_ok  = (r_o < OCW'(ORDER_COUNT - 1)) && (WW'(bud) < lim);
    assign asize   = LW'(1) << r_req;

    // next state and item registers
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_o     = r_o;
        n_p     = r_p;
        n_u     = r_u;
        n_half  = r_half;
        n_grant = r_grant;
        n_res   = r_res;
        head_we = 1'b0;
        head_wd = h;
        tail_we = 1'b0;
        tail_wd = t;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        total_we = 1'b0;
        total_wd = r_total;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == PW'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_grant = 1'b0;
                    n_res   = '0;
                    n_p     = PW'(i_req.block_index);
                    if (order_bad) begin
                        n_state = S_DONE;
                    end else begin
                        n_o = OCW'(i_req.order);
                        if (i_req.operation == OP_FREE) begin
                            n_state = idx_bad ? S_DONE : S_FCHK;
                        end else begin
                            n_state = S_ASCAN;
                        end
                    end
                end
            end
            S_ASCAN: begin
                if (r_o == OCW'(ORDER_COUNT)) begin
                    n_state = S_DONE;
                end else if (h >= NIL) begin
                    n_o = r_o + 1'b1;
                end else begin
                    n_p     = PW'(h);
                    n_u     = PW'(h);
                    n_state = S_UN1;
                end
            end
            S_UN1: begin
                if (rd_prev >= NIL) begin
                    head_we = 1'b1;
                    head_wd = rd_next;
                end
                n_state = S_UN2;
            end
            S_UN2: begin
                if (rd_next >= NIL) begin
                    tail_we = 1'b1;
                    tail_wd = rd_prev;
                end
                cnt_dec = 1'b1;
                n_state = S_UN3;
            end
            S_UN3: begin
                if (r_op == OP_ALLOC) begin
                    n_state = S_SPLIT;
                end else begin
                    n_p     = r_p & ~(PW'(1) << r_o);
                    n_o     = r_o + 1'b1;
                    n_state = S_FBUD;
                end
            end
            S_SPLIT: begin
                if (r_o > r_req) begin
                    n_o     = r_o - 1'b1;
                    n_half  = r_p + (PW'(1) << (r_o - 1'b1));
                    n_state = S_SPL2;
                end else begin
                    total_we = 1'b1;
                    total_wd = (r_total > asize) ? r_total - asize : '0;
                    n_grant  = 1'b1;
                    n_res    = r_p;
                    n_state  = S_DONE;
                end
            end
            S_SPL2: begin
                n_state = S_SPL3;
            end
            S_SPL3: begin
                if (t >= NIL) begin
                    head_we = 1'b1;
                    head_wd = LW'(r_half);
                end
                tail_we = 1'b1;
                tail_wd = LW'(r_half);
                cnt_inc = 1'b1;
                n_state = S_SPLIT;
            end
            S_FCHK: begin
                n_state = (aligned && fits) ? S_FDBL : S_DONE;
            end
            S_FDBL: begin
                if (rd_flag[OW]) begin
                    n_state = S_DONE;
                end else begin
                    total_we = 1'b1;
                    total_wd = (sum_w > WW'(NUM_PAGES)) ? NIL : LW'(sum_w);
                    n_state  = S_FBUD;
                end
            end
            S_FBUD: begin
                if (bud_ok) begin
                    n_u     = bud;
                    n_state = S_FBCK;
                end else begin
                    n_state = S_FPUSH;
                end
            end
            S_FBCK: begin
                if (rd_flag[OW] && (OCW'(rd_flag[OW-1:0]) == r_o)) begin
                    n_state = S_UN1;
                end else begin
                    n_state = S_FPUSH;
                end
            end
            S_FPUSH: begin
                n_state = S_FPSH2;
            end
            S_FPSH2: begin
                if (h >= NIL) begin
                    tail_we = 1'b1;
                    tail_wd = LW'(r_p);
                end
                head_we = 1'b1;
                head_wd = LW'(r_p);
                cnt_inc = 1'b1;
                n_grant = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // page store accesses
    always_comb begin
        mem_ctl = '0;
        rd_addr = r_p;
        wr_addr = r_p;
        wd_next = NIL;
        wd_prev = NIL;
        wd_flag = '0;
        case (r_state)
            S_CLEAR: begin
                mem_ctl.wr_next = 1'b1;
                mem_ctl.wr_prev = 1'b1;
                mem_ctl.wr_flag = 1'b1;
                wr_addr = r_clr;
                wd_next = '0;
                wd_prev = '0;
            end
            S_ASCAN: begin
                if ((r_o != OCW'(ORDER_COUNT)) && (h < NIL)) begin
                    mem_ctl.rd = 1'b1;
                    rd_addr    = PW'(h);
                end
            end
            S_UN1: begin
                if (rd_prev < NIL) begin
                    mem_ctl.wr_next = 1'b1;
                    wr_addr = PW'(rd_prev);
                    wd_next = rd_next;
                end
            end
            S_UN2: begin
                if (rd_next < NIL) begin
                    mem_ctl.wr_prev = 1'b1;
                    wr_addr = PW'(rd_next);
                    wd_prev = rd_prev;
                end
            end
            S_UN3: begin
                mem_ctl.wr_flag = 1'b1;
                wr_addr = r_u;
            end
            S_SPL2: begin
                mem_ctl.wr_next = 1'b1;
                mem_ctl.wr_prev = 1'b1;
                mem_ctl.wr_flag = 1'b1;
                wr_addr = r_half;
                wd_prev = t;
                wd_flag = {1'b1, oi};
            end
            S_SPL3: begin
                if (t < NIL) begin
                    mem_ctl.wr_next = 1'b1;
                    wr_addr = PW'(t);
                    wd_next = LW'(r_half);
                end
            end
            S_FCHK: begin
                mem_ctl.rd = aligned && fits;
            end
            S_FBUD: begin
                mem_ctl.rd = bud_ok;
                rd_addr    = bud;
            end
            S_FPUSH: begin
                mem_ctl.wr_next = 1'b1;
                mem_ctl.wr_prev = 1'b1;
                mem_ctl.wr_flag = 1'b1;
                wd_next = h;
                wd_flag = {1'b1, oi};
            end
            S_FPSH2: begin
                if (h < NIL) begin
                    mem_ctl.wr_prev = 1'b1;
                    wr_addr = PW'(h);
                    wd_prev = LW'(r_p);
                end
            end
            default: begin
                mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_zone  <= 13'd4096;
            r_total <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < ORDER_COUNT; k++) begin
                r_head[k] <= NIL;
                r_tail[k] <= NIL;
                r_cnt[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_zone_pages_we) begin
                r_zone <= i_zone_pages;
            end
            if (total_we) begin
                r_total <= total_wd;
            end
            if (head_we) begin
                r_head[oi] <= head_wd;
            end
            if (tail_we) begin
                r_tail[oi] <= tail_wd;
            end
            if (cnt_inc) begin
                r_cnt[oi] <= (r_cnt[oi] >= NIL) ? NIL : r_cnt[oi] + 1'b1;
            end else if (cnt_dec) begin
                r_cnt[oi] <= (r_cnt[oi] == '0) ? '0 : r_cnt[oi] - 1'b1;
            end
            if ((r_state == S_DONE) && (!r_ov || o_rsp.ready)) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o     <= n_o;
        r_p     <= n_p;
        r_u     <= n_u;
        r_half  <= n_half;
        r_grant <= n_grant;
        r_res   <= n_res;
        if (in_acc) begin
            r_op  <= i_req.operation;
            r_req <= OCW'(i_req.order);
        end
        if ((r_state == S_DONE) && (!r_ov || o_rsp.ready)) begin
            r_gr <= r_grant;
            r_ri <= r_res;
            r_fp <= r_total;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.granted         = r_gr;
    assign o_rsp.result_index    = INDEX_W'(r_ri);
    assign o_rsp.free_page_count = COUNT_W'(r_fp);

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= NIL)
        else $error("free page total above page count");

    a_no_reclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("clearing pass restarted");

    a_rd_wr_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_ctl.rd |-> !(mem_ctl.wr_next || mem_ctl.wr_prev || mem_ctl.wr_flag))
        else $error("page store read and written in one cycle");

    // a buddy read comes ahead of S_FBCK, the order check, not right before S_UN1
    a_unlink_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UN1) |-> ($past(mem_ctl.rd) || $past(mem_ctl.rd, 2)))
        else $error("unlink without fresh read data");

endmodule
`default_nettype wire

### verif/tb_alloc_checker.sv
`default_nettype none
module tb_alloc_checker import bpa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_zone_pages_we,
    input  wire logic [COUNT_W-1:0] i_zone_pages,
    bpa_req_if.sink                 req_mon,
    bpa_rsp_if.sink                 rsp_mon,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES  = 4096;
    localparam int ORDERS = 11;
    localparam int NIL    = PAGES;

    typedef struct packed {
        logic               granted;
        logic [INDEX_W-1:0] result_index;
        logic [COUNT_W-1:0] free_page_count;
    } t_grant;

    int     nxt [PAGES];
    int     prv [PAGES];
    bit     is_free [PAGES];
    int     ord_of [PAGES];
    int     head [ORDERS];
    int     tail [ORDERS];
    int     nblk [ORDERS];
    int     pages_free;
    int     zone;
    t_grant grant_q [$];
    int     fails;

    assign o_fail_count = fails;
    assign o_pending    = grant_q.size();

    function automatic int sat_up(int a, int b);
        return (a + b > PAGES) ? PAGES : a + b;
    endfunction

    function automatic int sat_dn(int a, int b);
        return (a > b) ? a - b : 0;
    endfunction

    function automatic void unlink(int o, int p);
        int n, q;
        n = nxt[p];
        q = prv[p];
        if (q < NIL) nxt[q] = n; else head[o] = n;
        if (n < NIL) prv[n] = q; else tail[o] = q;
        nblk[o] = sat_dn(nblk[o], 1);
    endfunction

    function automatic void link(int o, int p, bit at_head);
        if (at_head) begin
            nxt[p] = head[o];
            prv[p] = NIL;
            if (head[o] < NIL) prv[head[o]] = p; else tail[o] = p;
            head[o] = p;
        end else begin
            prv[p] = tail[o];
            nxt[p] = NIL;
            if (tail[o] < NIL) nxt[tail[o]] = p; else head[o] = p;
            tail[o] = p;
        end
        is_free[p] = 1'b1;
        ord_of[p]  = o;
        nblk[o]    = sat_up(nblk[o], 1);
    endfunction

    function automatic t_grant predict_grant(logic [OP_W-1:0] op, int order, int idx);
        t_grant g;
        int     lim, size, p, o;
        g = '0;
        if (order < ORDERS && op == OP_ALLOC) begin
            for (o = order; o < ORDERS; o++) begin
                p = head[o];
                if (p < NIL) break;
            end
            if (o < ORDERS) begin
                unlink(o, p);
                is_free[p] = 1'b0;
                while (o > order) begin
                    o--;
                    if (p + (1 << o) < NIL) link(o, p + (1 << o), 1'b0);
                end
                pages_free = sat_dn(pages_free, 1 << order);
                g.granted = 1'b1;
                g.result_index = INDEX_W'(p);
            end
        end else if (order < ORDERS) begin
            lim  = (zone > PAGES) ? PAGES : zone;
            size = 1 << order;
            if ((idx & (size - 1)) == 0 && idx < lim && size <= lim - idx
                    && !is_free[idx]) begin
                pages_free = sat_up(pages_free, size);
                while (order < ORDERS - 1) begin
                    p = idx ^ (1 << order);
                    if (p >= lim || !is_free[p] || ord_of[p] != order) break;
                    unlink(order, p);
                    is_free[p] = 1'b0;
                    idx &= ~(1 << order);
                    order++;
                end
                link(order, idx, 1'b1);
                g.granted = 1'b1;
            end
        end
        g.free_page_count = COUNT_W'(pages_free);
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want, got;
        if (!i_rst_n) begin
            foreach (is_free[i]) is_free[i] = 1'b0;
            foreach (head[o]) begin
                head[o] = NIL;
                tail[o] = NIL;
                nblk[o] = 0;
            end
            pages_free = 0;
            zone = PAGES;
            fails = 0;
            grant_q.delete();
        end else begin
            if (i_zone_pages_we) zone = int'(i_zone_pages);
            if (req_mon.valid && req_mon.ready)
                grant_q.push_back(predict_grant(req_mon.operation, int'(req_mon.order),
                                                int'(req_mon.block_index)));
            if (rsp_mon.valid && rsp_mon.ready) begin
                got = {rsp_mon.granted, rsp_mon.result_index, rsp_mon.free_page_count};
                if (grant_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = grant_q.pop_front();
                    if (want != got) begin
                        fails++;
                        if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               zone_we = 0;
    logic [COUNT_W-1:0] zone_val = COUNT_W'(4096);
    int                 fail_count, pending;
    int                 stall_cycles = 0;
    bit                 calm = 0;
    logic [INDEX_W-1:0] held [$];

    bpa_req_if req ();
    bpa_rsp_if rsp ();

    buddy_page_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_zone_pages_we(zone_we),
        .i_zone_pages(zone_val), .i_req(req.sink), .o_rsp(rsp.source)
    );

    tb_alloc_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_zone_pages_we(zone_we),
        .i_zone_pages(zone_val), .req_mon(req.sink), .rsp_mon(rsp.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    // random backpressure on the result side
    always @(negedge i_clk) begin
        if (calm || $urandom_range(0, 5) != 0) begin
            rsp.ready <= 1;
        end else begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 60000) begin
            $display("FAIL buddy_page_allocator_unit");
            $finish;
        end
    end

    // valid stays high after the beat; drain() or a random gap in the next call takes it down
    task automatic send_beat(logic [OP_W-1:0] op, int order, int idx);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req.valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        req.valid <= 1;
        req.operation <= op;
        req.order <= ORDER_W'(order);
        req.block_index <= INDEX_W'(idx);
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic set_zone(int v);
        drain();
        zone_we <= 1;
        zone_val <= COUNT_W'(v);
        @(negedge i_clk);
        zone_we <= 0;
    endtask

    // free pages 0 to pages-1 as order-0 and order-6 blocks
    task automatic fill_zone(int pages);
        int p;
        p = 0;
        while (p < pages) begin
            if (p % 64 == 0 && p + 64 <= pages) begin
                send_beat(OP_FREE, 6, p);
                p += 64;
            end else begin
                send_beat(OP_FREE, 0, p);
                p++;
            end
        end
    endtask

    task automatic random_mix(int n, int zone);
        int o, k, idx;
        repeat (n) begin
            o = $urandom_range(0, 10) < 9 ? $urandom_range(0, 4) : $urandom_range(0, 15);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    send_beat(OP_ALLOC, o, $urandom_range(0, 4095));
                end
                4, 5, 6, 7: begin
                    if (held.size() != 0) begin
                        k = $urandom_range(0, held.size() - 1);
                        idx = int'(held[k]);
                        held.delete(k);
                        send_beat(OP_FREE, $urandom_range(0, 3),
                                  idx & ~((1 << $urandom_range(0, 3)) - 1));
                    end else begin
                        send_beat(OP_FREE, 0, $urandom_range(0, zone - 1));
                    end
                end
                default: send_beat(OP_FREE, o, $urandom_range(0, 4095));
            endcase
        end
    endtask

    // record granted allocations at nonzero indices so later frees hit real blocks
    always @(posedge i_clk) begin
        if (rsp.valid && rsp.ready && rsp.granted && rsp.result_index != 0)
            held.push_back(rsp.result_index);
    end

    initial begin
        req.valid = 0;
        req.operation = OP_ALLOC;
        req.order = 0;
        req.block_index = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        // directed: empty free lists, bad orders, misaligned, double free
        send_beat(OP_ALLOC, 0, 0);
        send_beat(OP_ALLOC, 15, 4095);
        send_beat(OP_FREE, 11, 0);
        send_beat(OP_FREE, 3, 5);
        send_beat(OP_FREE, 10, 1024);
        send_beat(OP_FREE, 10, 0);
        send_beat(OP_FREE, 10, 0);
        send_beat(OP_FREE, 0, 4095);
        send_beat(OP_ALLOC, 0, 0);
        send_beat(OP_ALLOC, 10, 0);
        send_beat(OP_ALLOC, 10, 0);
        send_beat(OP_FREE, 0, 0);
        send_beat(OP_ALLOC, 9, 0);
        send_beat(OP_FREE, 9, 512);
        drain();
        set_zone(4096);
        fill_zone(256);
        random_mix(400, 256);
        set_zone(1);
        send_beat(OP_FREE, 0, 0);
        send_beat(OP_FREE, 1, 0);
        random_mix(150, 1);
        set_zone(200);
        random_mix(300, 200);
        set_zone(8191);
        send_beat(OP_FREE, 11, 2048);
        send_beat(OP_FREE, 11, 2048);
        random_mix(200, 4096);
        calm = 1;
        random_mix(200, 4096);
        drain();
        if (fail_count == 0) begin
            $display("PASS buddy_page_allocator_unit");
        end else begin
            $display("FAIL buddy_page_allocator_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
design/bpa_pkg.sv
design/bpa_req_if.sv
design/bpa_rsp_if.sv
design/bpa_page_mem.sv
design/buddy_page_allocator_unit.sv
verif/tb_alloc_checker.sv
verif/tb.sv
